@@ hw/rtl/hk_pkg.sv @@
// Shared types and constants for the hotkey matcher.
// Binding entry layout, modifier codes and the sequencer state encoding.
// No dependencies.
package hk_pkg;

    localparam int ACTION_LIMIT = 64;

    localparam logic [3:0] MASK_SHIFT = 4'h1;
    localparam logic [3:0] MASK_CTRL  = 4'h2;
    localparam logic [3:0] MASK_ALT   = 4'h4;
    localparam logic [3:0] MASK_SUPER = 4'h8;

    localparam logic [7:0] BREAK_BIT     = 8'h80;
    localparam logic [7:0] CODE_MASK     = 8'h7F;
    localparam logic [7:0] CODE_LSHIFT   = 8'h2A;
    localparam logic [7:0] CODE_RSHIFT   = 8'h36;
    localparam logic [7:0] CODE_CTRL     = 8'h1D;
    localparam logic [7:0] CODE_ALT      = 8'h38;
    localparam logic [7:0] CODE_LSUPER   = 8'h5B;
    localparam logic [7:0] CODE_RSUPER   = 8'h5C;

    localparam int ENTRY_W = 19;

    typedef struct packed {
        logic [5:0] act;
        logic       ext;
        logic [3:0] mods;
        logic [7:0] code;
    } entry_t;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_WRITE = 4'b0100,
        ST_OUT   = 4'b1000
    } state_t;

    // Modifier bit named by a scancode with the break bit stripped, or zero.
    function automatic logic [3:0] modifier_bit(input logic [7:0] code, input logic ext);
        logic [3:0] bit_v;
        bit_v = 4'h0;
        if (code == CODE_CTRL) begin
            bit_v = MASK_CTRL;
        end else if (code == CODE_ALT) begin
            bit_v = MASK_ALT;
        end else if (!ext && (code == CODE_LSHIFT || code == CODE_RSHIFT)) begin
            bit_v = MASK_SHIFT;
        end else if (ext && (code == CODE_LSUPER || code == CODE_RSUPER)) begin
            bit_v = MASK_SUPER;
        end
        return bit_v;
    endfunction

endpackage

@@ hw/rtl/hk_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// Holds the binding table; no dependencies.
module hk_ram #(
    parameter int WIDTH = 19,
    parameter int DEPTH = 64
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/hotkey_matcher_core.sv @@
// Hotkey matcher top level: modifier tracking, table walk and result register.
// Depends on hk_pkg and hk_ram.
//
// Usage:
//   Input beats arrive on s_t*: s_tuser is the command (0 = scancode,
//   1 = set binding), s_tdata carries the scancode and binding fields.
//   Each input beat yields exactly one result beat on m_t*.
//   Modifier and break codes skip the table walk and go straight to the output.
//   Lookups and set commands walk the binding table in one RAM, one entry
//   read per cycle with a registered read; a set command with no match
//   appends only below a full table. The block works on one item at a time;
//   s_tready is high while the sequencer is idle.
//   The result sits in an output register, so the next beat is taken while
//   the previous result still waits. If the receiver stalls, the finished
//   result of the following item holds in the sequencer until the output
//   register frees up.
//   Reset clears the held modifiers and the entry count, so the table is
//   empty; no clearing pass over the RAM is needed.
module hotkey_matcher_core
    import hk_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] key_code, [8] is_extended, [12:9] binding_modifiers,
    // [18:13] binding_action, [23:19] zero
    input  logic [23:0] s_tdata,
    // [0] command
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [5:0] action_code, [6] table_full, [10:7] modifier_state, [15:11] zero
    output logic [15:0] m_tdata
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
    localparam logic [8:0] ACT_LIM_C = 9'(ACTION_LIMIT);

    state_t state_reg, state_next;

    logic [3:0]    held_reg, held_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          pend_reg, pend_next;
    logic [AW-1:0] chk_reg, chk_next;
    logic [AW-1:0] wa_reg, wa_next;

    logic          cmd_reg, cmd_next;
    entry_t        item_reg, item_next;

    logic [5:0]    res_act_reg, res_act_next;
    logic          res_full_reg, res_full_next;

    logic          m_valid_reg, m_valid_next;
    logic [5:0]    m_act_reg, m_act_next;
    logic          m_full_reg, m_full_next;
    logic [3:0]    m_mods_reg, m_mods_next;

    logic          s_fire;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    entry_t        rd_entry;
    logic [ENTRY_W-1:0] rd_data;
    entry_t        in_item;
    logic [3:0]    in_bit;
    logic          in_brk;
    logic          hit;

    hk_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wa_reg),
        .wdata (item_reg),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    assign rd_entry = entry_t'(rd_data);

    assign in_item.code = s_tdata[7:0];
    assign in_item.ext  = s_tdata[8];
    assign in_item.mods = s_tdata[12:9];
    assign in_item.act  = s_tdata[18:13];
    assign in_bit = modifier_bit(in_item.code & CODE_MASK, in_item.ext);
    assign in_brk = |(in_item.code & BREAK_BIT);

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;

    // Lookup compares key, held modifiers and extended flag; set compares action.
    always_comb begin
        if (cmd_reg) begin
            hit = (rd_entry.act == item_reg.act);
        end else begin
            hit = (rd_entry.code == item_reg.code) && (rd_entry.mods == held_reg) &&
                  (rd_entry.ext == item_reg.ext);
        end
    end

    always_comb begin
        state_next    = state_reg;
        held_next     = held_reg;
        cnt_next      = cnt_reg;
        idx_next      = idx_reg;
        pend_next     = pend_reg;
        chk_next      = chk_reg;
        wa_next       = wa_reg;
        cmd_next      = cmd_reg;
        item_next     = item_reg;
        res_act_next  = res_act_reg;
        res_full_next = res_full_reg;
        m_valid_next  = m_valid_reg;
        m_act_next    = m_act_reg;
        m_full_next   = m_full_reg;
        m_mods_next   = m_mods_reg;
        rd_en         = 1'b0;
        rd_addr       = idx_reg[AW-1:0];
        wr_en         = 1'b0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    cmd_next      = s_tuser;
                    item_next     = in_item;
                    res_act_next  = 6'd0;
                    res_full_next = 1'b0;
                    idx_next      = '0;
                    pend_next     = 1'b0;
                    if (s_tuser) begin
                        // Ignore actions outside the allowed range.
                        if ({3'b000, in_item.act} >= ACT_LIM_C) begin
                            state_next = ST_OUT;
                        end else begin
                            state_next = ST_SCAN;
                        end
                    end else if (in_bit != 4'h0) begin
                        held_next  = in_brk ? (held_reg & ~in_bit) : (held_reg | in_bit);
                        state_next = ST_OUT;
                    end else if (in_brk) begin
                        state_next = ST_OUT;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (pend_reg && hit) begin
                    pend_next = 1'b0;
                    if (cmd_reg) begin
                        wa_next    = chk_reg;
                        state_next = ST_WRITE;
                    end else begin
                        res_act_next = rd_entry.act;
                        state_next   = ST_OUT;
                    end
                end else if (idx_reg < cnt_reg) begin
                    // Issue the next read while the previous entry is compared.
                    rd_en     = 1'b1;
                    idx_next  = idx_reg + CW'(1);
                    pend_next = 1'b1;
                    chk_next  = idx_reg[AW-1:0];
                end else if (pend_reg) begin
                    pend_next = 1'b0;
                end else if (cmd_reg) begin
                    if (cnt_reg == DEPTH_C) begin
                        res_full_next = 1'b1;
                        state_next    = ST_OUT;
                    end else begin
                        wa_next    = cnt_reg[AW-1:0];
                        cnt_next   = cnt_reg + CW'(1);
                        state_next = ST_WRITE;
                    end
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_WRITE: begin
                wr_en      = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_act_next   = res_act_reg;
                    m_full_next  = res_full_reg;
                    m_mods_next  = held_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            held_reg    <= 4'h0;
            cnt_reg     <= '0;
            idx_reg     <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            held_reg    <= held_next;
            cnt_reg     <= cnt_next;
            idx_reg     <= idx_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        chk_reg      <= chk_next;
        wa_reg       <= wa_next;
        cmd_reg      <= cmd_next;
        item_reg     <= item_next;
        res_act_reg  <= res_act_next;
        res_full_reg <= res_full_next;
        m_act_reg    <= m_act_next;
        m_full_reg   <= m_full_next;
        m_mods_reg   <= m_mods_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b00000, m_mods_reg, m_full_reg, m_act_reg};

endmodule
